### sv/polygon_point_inside_parity_macros.svh
// Assertion helpers used by the datapath.
`ifndef POLYGON_POINT_INSIDE_PARITY_MACROS_SVH
`define POLYGON_POINT_INSIDE_PARITY_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition must hold at every clock edge out of reset.
`define PPIP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define PPIP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define PPIP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PPIP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/ppip_pkg.sv
`default_nettype none
package ppip_pkg;

	// Sizing of the edge store and the coordinate arithmetic
	localparam int MAX_EDGES  = 128;
	localparam int COORD_BITS = 12;
	localparam int ADDR_W     = $clog2(MAX_EDGES);
	localparam int CNT_W      = $clog2(MAX_EDGES + 1);
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int ORI_W      = PROD_W + 1;

	// Fixed port widths
	localparam int OP_W    = 2;
	localparam int IN_W    = 12;
	localparam int STAT_W  = 2;
	localparam int CROSS_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_QUERY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_DRAIN,
		S_RESP
	} state_t;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ORI_W-1:0] ori_t;

	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
	} edge_t;

	// Controller to datapath
	typedef struct packed {
		logic load_item;
		logic exec;
		logic rd_en;
		logic out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_query;
		logic count_zero;
		logic walk_last;
		logic pipe_busy;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

### sv/ppip_datapath.sv
`default_nettype none
`include "polygon_point_inside_parity_macros.svh"
module ppip_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppip_pkg::dp_cmd_t           cmd,
	output ppip_pkg::dp_stat_t          stat,
	input  logic [ppip_pkg::OP_W-1:0]   op,
	input  logic [ppip_pkg::IN_W-1:0]   ax,
	input  logic [ppip_pkg::IN_W-1:0]   ay,
	input  logic [ppip_pkg::IN_W-1:0]   bx,
	input  logic [ppip_pkg::IN_W-1:0]   by,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [ppip_pkg::STAT_W-1:0] status,
	output logic                        inside_res,
	output logic [ppip_pkg::CROSS_W-1:0] crossings
);
	import ppip_pkg::*;

	function automatic diff_t coord_diff(coord_t a, coord_t b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	logic [OP_W-1:0]    op_q;
	edge_t              pt_q;
	logic [CNT_W-1:0]   edge_count_q;
	logic [ADDR_W-1:0]  rd_addr_q;
	logic [STAT_W-1:0]  res_status_q;
	logic [CROSS_W-1:0] cross_cnt_q;
	logic               parity_q;
	logic               full;

	edge_t edge_mem [MAX_EDGES];

	edge_t rd_edge_s1;
	logic  v_s1, v_s2, v_s3, v_s4;
	diff_t dex_s2, dey_s2, dpx_s2, dpy_s2;
	diff_t u0x_s2, u0y_s2, u1x_s2, u1y_s2;
	diff_t w0x_s2, w0y_s2, w1x_s2, w1y_s2;
	prod_t m_s3 [8];
	logic  cross_s4;
	logic  cross_c;
	ori_t  ori_c [4];
	logic  [3:0] pos_c, neg_c;

	logic [STAT_W-1:0]  status_q;
	logic               inside_q;
	logic [CROSS_W-1:0] crossings_q;
	logic               out_valid_q;

	assign full = edge_count_q >= CNT_W'(MAX_EDGES);

	// Status toward the controller
	always_comb begin
		stat.is_query   = op_q == OP_QUERY;
		stat.count_zero = edge_count_q == '0;
		stat.walk_last  = (CNT_W'(rd_addr_q) + CNT_W'(1)) == edge_count_q;
		stat.pipe_busy  = v_s1 | v_s2 | v_s3 | v_s4;
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// Capture the request and keep only the low coordinate bits
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q    <= op;
			pt_q.x0 <= coord_t'(ax);
			pt_q.y0 <= coord_t'(ay);
			pt_q.x1 <= coord_t'(bx);
			pt_q.y1 <= coord_t'(by);
		end
	end

	// Edge count: clear or advance on execution
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
		end else if (cmd.exec) begin
			case (op_q)
				OP_CLEAR:  edge_count_q <= '0;
				OP_APPEND: if (!full) edge_count_q <= edge_count_q + CNT_W'(1);
				default:   edge_count_q <= edge_count_q;
			endcase
		end
	end

	// Result code of the request under way
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			case (op_q)
				OP_QUERY:  res_status_q <= ST_QUERY;
				OP_APPEND: res_status_q <= full ? ST_FULL : ST_OK;
				default:   res_status_q <= ST_OK;
			endcase
		end
	end

	// Edge memory: write the appended edge, read one edge per walk cycle
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_APPEND && !full)
			edge_mem[edge_count_q[ADDR_W-1:0]] <= pt_q;
		if (cmd.rd_en)
			rd_edge_s1 <= edge_mem[rd_addr_q];
	end

	// Walk address and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
		end else begin
			if (cmd.exec)
				rd_addr_q <= '0;
			else if (cmd.rd_en)
				rd_addr_q <= rd_addr_q + ADDR_W'(1);
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 2: coordinate differences
	always_ff @(posedge clk) begin
		dex_s2 <= coord_diff(rd_edge_s1.x1, rd_edge_s1.x0);
		dey_s2 <= coord_diff(rd_edge_s1.y1, rd_edge_s1.y0);
		dpx_s2 <= coord_diff(pt_q.x1, pt_q.x0);
		dpy_s2 <= coord_diff(pt_q.y1, pt_q.y0);
		u0x_s2 <= coord_diff(pt_q.x0, rd_edge_s1.x0);
		u0y_s2 <= coord_diff(pt_q.y0, rd_edge_s1.y0);
		u1x_s2 <= coord_diff(pt_q.x1, rd_edge_s1.x0);
		u1y_s2 <= coord_diff(pt_q.y1, rd_edge_s1.y0);
		w0x_s2 <= coord_diff(rd_edge_s1.x0, pt_q.x0);
		w0y_s2 <= coord_diff(rd_edge_s1.y0, pt_q.y0);
		w1x_s2 <= coord_diff(rd_edge_s1.x1, pt_q.x0);
		w1y_s2 <= coord_diff(rd_edge_s1.y1, pt_q.y0);
	end

	// Stage 3: the eight cross-product terms
	always_ff @(posedge clk) begin
		m_s3[0] <= dex_s2 * u0y_s2;
		m_s3[1] <= dey_s2 * u0x_s2;
		m_s3[2] <= dex_s2 * u1y_s2;
		m_s3[3] <= dey_s2 * u1x_s2;
		m_s3[4] <= dpx_s2 * w0y_s2;
		m_s3[5] <= dpy_s2 * w0x_s2;
		m_s3[6] <= dpx_s2 * w1y_s2;
		m_s3[7] <= dpy_s2 * w1x_s2;
	end

	// Stage 4: orientation signs; a zero counts as touching
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ori_c[k] = ori_t'(m_s3[2*k]) - ori_t'(m_s3[2*k+1]);
			pos_c[k] = ori_c[k] > 0;
			neg_c[k] = ori_c[k] < 0;
		end
		cross_c = !((pos_c[0] & pos_c[1]) | (neg_c[0] & neg_c[1])) &&
		          !((pos_c[2] & pos_c[3]) | (neg_c[2] & neg_c[3]));
	end

	always_ff @(posedge clk) begin
		cross_s4 <= cross_c;
	end

	// Crossing count, saturating, with the full-count parity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_cnt_q <= '0;
			parity_q    <= 1'b0;
		end else if (cmd.exec) begin
			cross_cnt_q <= '0;
			parity_q    <= 1'b0;
		end else if (v_s4 && cross_s4) begin
			if (cross_cnt_q != '1)
				cross_cnt_q <= cross_cnt_q + CROSS_W'(1);
			parity_q <= !parity_q;
		end
	end

	// Output register: load the result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q    <= res_status_q;
			inside_q    <= parity_q;
			crossings_q <= cross_cnt_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign inside_res = inside_q;
	assign crossings  = crossings_q;

	`PPIP_ASSERT_ALWAYS(a_count_range, clk, arst_n, edge_count_q <= CNT_W'(MAX_EDGES))
	`PPIP_ASSERT_IMPLIES(a_read_stored, clk, arst_n, cmd.rd_en, CNT_W'(rd_addr_q) < edge_count_q)
	`PPIP_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || !out_stall)
	`PPIP_ASSERT_IMPLIES(a_parity, clk, arst_n, cross_cnt_q != '1, parity_q == cross_cnt_q[0])

endmodule
`default_nettype wire

### sv/ppip_ctrl.sv
`default_nettype none
module ppip_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ppip_pkg::dp_stat_t stat,
	output ppip_pkg::dp_cmd_t  cmd
);
	import ppip_pkg::*;

	state_t state_q, state_d;
	logic   in_acc;

	assign in_acc = in_valid && !in_stall;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_acc) state_d = S_EXEC;
			S_EXEC: begin
				if (stat.is_query && !stat.count_zero)
					state_d = S_WALK;
				else
					state_d = S_RESP;
			end
			S_WALK:  if (stat.walk_last) state_d = S_DRAIN;
			S_DRAIN: if (!stat.pipe_busy) state_d = S_RESP;
			S_RESP:  if (stat.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		in_stall      = 1'b1;
		cmd.load_item = 1'b0;
		cmd.exec      = 1'b0;
		cmd.rd_en     = 1'b0;
		cmd.out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall      = 1'b0;
				cmd.load_item = in_valid;
			end
			S_EXEC:  cmd.exec = 1'b1;
			S_WALK:  cmd.rd_en = 1'b1;
			S_DRAIN: cmd.rd_en = 1'b0;
			S_RESP:  cmd.out_load = stat.out_free;
			default: in_stall = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

### sv/polygon_point_inside_parity.sv
// Channel   Signals                       Moves
// in        in_valid / in_stall           request: op, ax, ay, bx, by
// out       out_valid / out_stall         result: status, inside_res, crossings
//
// Clear, append and unused codes go from execute to the response state, as does a
// query of an empty polygon; a query of N stored edges walks them, one edge per cycle
// from the edge memory into a four-stage orientation pipeline that then drains.
// Reset clears the edge count; the edge memory needs no clearing pass.
// One request is in work at a time; the next is taken while a result waits
// on out_stall, and a finished result then holds until the output is free.
`default_nettype none
module polygon_point_inside_parity (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ppip_pkg::OP_W-1:0]    op,
	input  logic [ppip_pkg::IN_W-1:0]    ax,
	input  logic [ppip_pkg::IN_W-1:0]    ay,
	input  logic [ppip_pkg::IN_W-1:0]    bx,
	input  logic [ppip_pkg::IN_W-1:0]    by,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ppip_pkg::STAT_W-1:0]  status,
	output logic                         inside_res,
	output logic [ppip_pkg::CROSS_W-1:0] crossings
);
	import ppip_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ppip_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ppip_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op         (op),
		.ax         (ax),
		.ay         (ay),
		.bx         (bx),
		.by         (by),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.inside_res (inside_res),
		.crossings  (crossings)
	);

endmodule
`default_nettype wire
